[src/sprite_anim_cel_select_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sprite animation cel selector
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ANIM_CEL_SELECT_MACROS_SVH
`define SPRITE_ANIM_CEL_SELECT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SACEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SACEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SACEL_ASSERT_IMP(lbl, ante, cons, msg)
`define SACEL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[src/sacel_pkg.sv]
// ----------------------------------------------------------------------------
// sacel_pkg
// Shared types, field widths, codes and the control store of the cel selector.
// ----------------------------------------------------------------------------
package sacel_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned VALUE_W    = 31;
  localparam int unsigned CEL_W      = 5;
  localparam int unsigned TOTAL_W    = 22;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned MAX_CELS      = 32;
  localparam int unsigned SEQ_DEPTH_DEF = 64;

  // Commands
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PREP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Animation modes (anything else runs as a loop)
  localparam logic [MODE_W-1:0] MODE_ONCE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PING = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANIM_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CEL_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_TIME  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_TIME   = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   entry_index;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [CEL_W-1:0]   cel;
    logic [TOTAL_W-1:0] total_time;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

  // Microprogram
  localparam int unsigned PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t ST_EMIT   = 5'd0;
  localparam pc_t ST_FETCH  = 5'd1;
  localparam pc_t ST_DISP0  = 5'd2;
  localparam pc_t ST_DISP1  = 5'd3;
  localparam pc_t ST_DISP2  = 5'd4;
  localparam pc_t ST_WR     = 5'd5;
  localparam pc_t ST_PREP   = 5'd6;
  localparam pc_t ST_PREP1  = 5'd7;
  localparam pc_t ST_PREP2  = 5'd8;
  localparam pc_t ST_SW0    = 5'd9;
  localparam pc_t ST_SW1    = 5'd10;
  localparam pc_t ST_SW2    = 5'd11;
  localparam pc_t ST_PMUL   = 5'd12;
  localparam pc_t ST_QRY    = 5'd13;
  localparam pc_t ST_QMOD   = 5'd14;
  localparam pc_t ST_QMODW  = 5'd15;
  localparam pc_t ST_QM2    = 5'd16;
  localparam pc_t ST_QW0    = 5'd17;
  localparam pc_t ST_QW1    = 5'd18;
  localparam pc_t ST_QMAP   = 5'd19;
  localparam pc_t ST_QDIV   = 5'd20;
  localparam pc_t ST_QDIVW  = 5'd21;
  localparam pc_t ST_QD2    = 5'd22;
  localparam pc_t ST_QD3    = 5'd23;
  localparam pc_t ST_QD4    = 5'd24;
  localparam pc_t ST_QHOLD  = 5'd25;
  localparam pc_t ST_CLR    = 5'd26;
  localparam pc_t ST_CLRX   = 5'd27;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_WRITE,
    OP_PREP_FIRST,
    OP_PREP_LAST,
    OP_RD_START,
    OP_SWEEP,
    OP_SWEEP_END,
    OP_PASS_MUL,
    OP_MOD_START,
    OP_TAKE_REM,
    OP_WALK,
    OP_MAP,
    OP_DIV_START,
    OP_DIVLEN_START,
    OP_TAKE_POS,
    OP_HOLD,
    OP_CLEAR,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_INPUT,
    C_CMD_PREP,
    C_CMD_QUERY,
    C_CMD_OTHER,
    C_NOT_USED,
    C_NOT_LAST,
    C_ONCE_HOLD,
    C_DIV_BUSY,
    C_WALK_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } uword_t;

  // Control store: jump to target when the condition holds, else step on.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      ST_EMIT:  w = '{OP_EMIT,         C_OUT_BUSY,  ST_EMIT};
      ST_FETCH: w = '{OP_ACCEPT,       C_NO_INPUT,  ST_FETCH};
      ST_DISP0: w = '{OP_NOP,          C_CMD_PREP,  ST_PREP};
      ST_DISP1: w = '{OP_NOP,          C_CMD_QUERY, ST_QRY};
      ST_DISP2: w = '{OP_NOP,          C_CMD_OTHER, ST_EMIT};
      ST_WR:    w = '{OP_WRITE,        C_ALWAYS,    ST_EMIT};
      ST_PREP:  w = '{OP_PREP_FIRST,   C_NONE,      ST_FETCH};
      ST_PREP1: w = '{OP_PREP_LAST,    C_NONE,      ST_FETCH};
      ST_PREP2: w = '{OP_NOP,          C_NOT_USED,  ST_PMUL};
      ST_SW0:   w = '{OP_RD_START,     C_NONE,      ST_FETCH};
      ST_SW1:   w = '{OP_SWEEP,        C_NOT_LAST,  ST_SW1};
      ST_SW2:   w = '{OP_SWEEP_END,    C_ALWAYS,    ST_EMIT};
      ST_PMUL:  w = '{OP_PASS_MUL,     C_ALWAYS,    ST_EMIT};
      ST_QRY:   w = '{OP_NOP,          C_ONCE_HOLD, ST_QHOLD};
      ST_QMOD:  w = '{OP_MOD_START,    C_NONE,      ST_FETCH};
      ST_QMODW: w = '{OP_NOP,          C_DIV_BUSY,  ST_QMODW};
      ST_QM2:   w = '{OP_TAKE_REM,     C_NOT_USED,  ST_QDIV};
      ST_QW0:   w = '{OP_RD_START,     C_NONE,      ST_FETCH};
      ST_QW1:   w = '{OP_WALK,         C_WALK_MORE, ST_QW1};
      ST_QMAP:  w = '{OP_MAP,          C_ALWAYS,    ST_EMIT};
      ST_QDIV:  w = '{OP_DIV_START,    C_NONE,      ST_FETCH};
      ST_QDIVW: w = '{OP_NOP,          C_DIV_BUSY,  ST_QDIVW};
      ST_QD2:   w = '{OP_DIVLEN_START, C_NONE,      ST_FETCH};
      ST_QD3:   w = '{OP_NOP,          C_DIV_BUSY,  ST_QD3};
      ST_QD4:   w = '{OP_TAKE_POS,     C_ALWAYS,    ST_QMAP};
      ST_QHOLD: w = '{OP_HOLD,         C_ALWAYS,    ST_EMIT};
      ST_CLR:   w = '{OP_CLEAR,        C_NOT_LAST,  ST_CLR};
      ST_CLRX:  w = '{OP_NOP,          C_ALWAYS,    ST_FETCH};
      default:  w = '{OP_NOP,          C_ALWAYS,    ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

[src/sacel_chan_if.sv]
// ----------------------------------------------------------------------------
// sacel_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface sacel_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/sacel_div.sv]
// ----------------------------------------------------------------------------
// sacel_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sacel_div #(
  parameter int unsigned DW = sacel_pkg::VALUE_W,
  parameter int unsigned VW = sacel_pkg::TOTAL_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] acc_q, acc_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;

  always_comb begin
    shifted = {rem_q, acc_q[DW-1]};
    diff    = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DW);
      acc_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // Subtract when the shifted remainder covers the divisor.
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = VW'(diff);
        acc_d = {acc_q[DW-2:0], 1'b1};
      end else begin
        rem_d = VW'(shifted);
        acc_d = {acc_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = acc_q;
  assign rem_o  = rem_q;

endmodule

[src/sprite_anim_cel_select.sv]
// ----------------------------------------------------------------------------
// sprite_anim_cel_select: elapsed ticks to animation cel, one item at a time
// Items: write, prepare (pass multiply, or table sweep) and query (held once,
// table walk or divide); each result is loaded into the output register.
// Throughput: one item in flight; the next transfer is taken after its result loads.
// Reset: store cleared entry by entry, input held off, config writes taken.
// ----------------------------------------------------------------------------
`include "sprite_anim_cel_select_macros.svh"

module sprite_anim_cel_select #(
  parameter int unsigned SEQ_DEPTH = sacel_pkg::SEQ_DEPTH_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  sacel_chan_if.sink  cfg_i,
  sacel_chan_if.sink  in_i,
  sacel_chan_if.source out_o
);
  import sacel_pkg::*;

  localparam int unsigned AW   = $clog2(SEQ_DEPTH);
  localparam int unsigned LW   = $clog2(SEQ_DEPTH + 1);
  localparam int unsigned PT_W = $clog2(SEQ_DEPTH * 65535 + 1);

  // Sequencer
  pc_t    pc_q, pc_d;
  uword_t uw;
  logic   jump;

  // Configuration registers
  logic [MODE_W-1:0]  mode_q;
  logic [DELAY_W-1:0] frame_delay_q;
  logic [CNT_W-1:0]   cel_count_q;
  logic [DELAY_W-1:0] first_time_q;
  logic [DELAY_W-1:0] last_time_q;

  // Sequence state
  logic            used_q, used_d;
  logic [LW-1:0]   seq_len_q, seq_len_d;
  logic [PT_W-1:0] pass_q, pass_d;
  logic [AW-1:0]   ptr_q, ptr_d;

  // Item payload and scratch
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [VALUE_W-1:0] val_q, val_d;
  logic [CEL_W-1:0]   cel_q, cel_d;
  logic [PT_W-1:0]    t_q, t_d;
  logic [LW-1:0]      pos_q, pos_d;
  logic [PT_W-1:0]    acc_q, acc_d;

  // Output register
  logic               out_vld_q, out_vld_d;
  logic [CEL_W-1:0]   out_cel_q, out_cel_d;
  logic [TOTAL_W-1:0] out_total_q, out_total_d;

  // Delay store
  logic [DELAY_W-1:0] mem [SEQ_DEPTH];
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [DELAY_W-1:0] wr_data;
  logic [AW-1:0]      rd_addr;
  logic [DELAY_W-1:0] rd_q;

  // Divider hookup
  logic               div_start;
  logic [VALUE_W-1:0] div_dividend;
  logic [PT_W-1:0]    div_divisor;
  logic               div_busy;
  logic [VALUE_W-1:0] div_quot;
  logic [PT_W-1:0]    div_rem;

  // Derived values
  logic [DELAY_W-1:0] fd_eff;
  logic [PT_W-1:0]    total_eff;
  logic [CNT_W-1:0]   n_nz;
  logic [7:0]         n_cl;
  logic [7:0]         len_raw;
  logic [LW-1:0]      len_new;
  logic [LW-1:0]      half;
  logic [LW-1:0]      mapped;
  logic               in_seq;
  logic [DELAY_W-1:0] sw_val;
  logic               walk_lt;

  assign fd_eff    = (frame_delay_q == '0) ? DELAY_W'(1) : frame_delay_q;
  assign total_eff = (pass_q == '0) ? PT_W'(1) : pass_q;

  // Sequence length for prepare: clamp the cel count; ping-pong runs 2n-2 positions.
  assign n_nz    = (cel_count_q == '0) ? CNT_W'(1) : cel_count_q;
  assign n_cl    = (32'(n_nz) > MAX_CELS) ? 8'(MAX_CELS) : 8'(n_nz);
  assign len_raw = (mode_q == MODE_PING && n_cl > 8'd1) ? ((n_cl << 1) - 8'd2) : n_cl;
  assign len_new = (32'(len_raw) > SEQ_DEPTH) ? LW'(SEQ_DEPTH) : LW'(len_raw);

  // Ping-pong fold: positions past the turn run back down.
  assign half   = (seq_len_q >> 1) + LW'(1);
  assign mapped = (mode_q == MODE_PING && seq_len_q >= LW'(2))
                ? ((pos_q < half) ? pos_q
                                  : ((seq_len_q >= pos_q) ? (seq_len_q - pos_q) : '0))
                : pos_q;

  // Sweep: fill empty positions with the default delay, clear the tail.
  assign in_seq  = (LW'(ptr_q) < seq_len_q);
  assign sw_val  = in_seq ? ((rd_q == '0) ? fd_eff : rd_q) : '0;
  assign walk_lt = (t_q < PT_W'(rd_q));

  // Control word fetch and branch
  always_comb begin
    uw = ucode(pc_q);
    unique case (uw.cond)
      C_NONE:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_INPUT:  jump = !in_i.valid;
      C_CMD_PREP:  jump = (cmd_q == CMD_PREP);
      C_CMD_QUERY: jump = (cmd_q == CMD_QUERY);
      C_CMD_OTHER: jump = (cmd_q != CMD_WRITE) && (cmd_q != CMD_PREP)
                          && (cmd_q != CMD_QUERY);
      C_NOT_USED:  jump = !used_q;
      C_NOT_LAST:  jump = (ptr_q != AW'(SEQ_DEPTH - 1));
      C_ONCE_HOLD: jump = (mode_q == MODE_ONCE) && (32'(val_q) >= 32'(total_eff));
      C_DIV_BUSY:  jump = div_busy;
      C_WALK_MORE: jump = !walk_lt && ((LW'(ptr_q) + LW'(1)) < seq_len_q);
      C_OUT_BUSY:  jump = out_vld_q && !out_o.ready;
      default:     jump = 1'b0;
    endcase
    pc_d = jump ? uw.target : pc_q + PC_W'(1);
  end

  // Datapath driven by the current control word
  always_comb begin
    used_d       = used_q;
    seq_len_d    = seq_len_q;
    pass_d       = pass_q;
    ptr_d        = ptr_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    val_d        = val_q;
    cel_d        = cel_q;
    t_d          = t_q;
    pos_d        = pos_q;
    acc_d        = acc_q;
    out_vld_d    = out_vld_q;
    out_cel_d    = out_cel_q;
    out_total_d  = out_total_q;
    wr_en        = 1'b0;
    wr_addr      = ptr_q;
    wr_data      = '0;
    rd_addr      = '0;
    div_start    = 1'b0;
    div_dividend = val_q;
    div_divisor  = total_eff;
    in_i.ready   = 1'b0;

    // Drop the held result once it transfers.
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (uw.op)
      OP_NOP: begin
      end
      OP_ACCEPT: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          cmd_d = in_i.data.command;
          idx_d = in_i.data.entry_index;
          val_d = in_i.data.value;
          cel_d = '0;
        end
      end
      OP_WRITE: begin
        // Saturate to the store width; ignore positions past the store.
        if (32'(idx_q) < SEQ_DEPTH) begin
          wr_en   = 1'b1;
          wr_addr = AW'(idx_q);
          wr_data = (val_q > VALUE_W'(16'hFFFF)) ? 16'hFFFF : val_q[DELAY_W-1:0];
          used_d  = 1'b1;
        end
      end
      OP_PREP_FIRST: begin
        seq_len_d = len_new;
        if (first_time_q != '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = first_time_q;
          used_d  = 1'b1;
        end
      end
      OP_PREP_LAST: begin
        if (last_time_q != '0) begin
          wr_en   = 1'b1;
          wr_addr = AW'(seq_len_q - LW'(1));
          wr_data = last_time_q;
          used_d  = 1'b1;
        end
      end
      OP_RD_START: begin
        rd_addr = '0;
        ptr_d   = '0;
        acc_d   = '0;
        pos_d   = seq_len_q - LW'(1);
      end
      OP_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        wr_data = sw_val;
        acc_d   = acc_q + PT_W'(sw_val);
        rd_addr = ptr_q + AW'(1);
        ptr_d   = ptr_q + AW'(1);
      end
      OP_SWEEP_END: begin
        pass_d = acc_q;
      end
      OP_PASS_MUL: begin
        pass_d = PT_W'(fd_eff) * PT_W'(seq_len_q);
      end
      OP_MOD_START: begin
        div_start    = 1'b1;
        div_dividend = val_q;
        div_divisor  = total_eff;
      end
      OP_TAKE_REM: begin
        t_d = div_rem;
      end
      OP_WALK: begin
        // Stop at the first position whose delay exceeds the remaining time.
        if (walk_lt) begin
          pos_d = LW'(ptr_q);
        end else begin
          t_d = t_q - PT_W'(rd_q);
        end
        rd_addr = ptr_q + AW'(1);
        ptr_d   = ptr_q + AW'(1);
      end
      OP_MAP: begin
        cel_d = CEL_W'(mapped);
      end
      OP_DIV_START: begin
        div_start    = 1'b1;
        div_dividend = VALUE_W'(t_q);
        div_divisor  = PT_W'(fd_eff);
      end
      OP_DIVLEN_START: begin
        div_start    = 1'b1;
        div_dividend = div_quot;
        div_divisor  = PT_W'(seq_len_q);
      end
      OP_TAKE_POS: begin
        pos_d = LW'(div_rem);
      end
      OP_HOLD: begin
        cel_d = CEL_W'(seq_len_q - LW'(1));
      end
      OP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        wr_data = '0;
        ptr_d   = ptr_q + AW'(1);
      end
      OP_EMIT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d   = 1'b1;
          out_cel_d   = cel_q;
          out_total_d = TOTAL_W'(pass_q);
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q          <= ST_CLR;
      ptr_q         <= '0;
      used_q        <= 1'b0;
      seq_len_q     <= LW'(1);
      pass_q        <= PT_W'(1);
      out_vld_q     <= 1'b0;
      mode_q        <= '0;
      frame_delay_q <= DELAY_W'(1);
      cel_count_q   <= CNT_W'(1);
      first_time_q  <= '0;
      last_time_q   <= '0;
    end else begin
      pc_q      <= pc_d;
      ptr_q     <= ptr_d;
      used_q    <= used_d;
      seq_len_q <= seq_len_d;
      pass_q    <= pass_d;
      out_vld_q <= out_vld_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          REG_ANIM_MODE:   mode_q        <= cfg_i.data.wdata[MODE_W-1:0];
          REG_FRAME_DELAY: frame_delay_q <= cfg_i.data.wdata[DELAY_W-1:0];
          REG_CEL_COUNT:   cel_count_q   <= cfg_i.data.wdata[CNT_W-1:0];
          REG_FIRST_TIME:  first_time_q  <= cfg_i.data.wdata[DELAY_W-1:0];
          REG_LAST_TIME:   last_time_q   <= cfg_i.data.wdata[DELAY_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  assign cfg_i.ready = 1'b1;

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    idx_q       <= idx_d;
    val_q       <= val_d;
    cel_q       <= cel_d;
    t_q         <= t_d;
    pos_q       <= pos_d;
    acc_q       <= acc_d;
    out_cel_q   <= out_cel_d;
    out_total_q <= out_total_d;
  end

  // Delay store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  sacel_div #(
    .DW (VALUE_W),
    .VW (PT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign out_o.valid           = out_vld_q;
  assign out_o.data.cel        = out_cel_q;
  assign out_o.data.total_time = out_total_q;

  `SACEL_ASSERT_NXT(a_accept_dispatch, in_i.valid && in_i.ready, pc_q == ST_DISP0, "accepted item not dispatched")
  `SACEL_ASSERT_IMP(a_div_start_idle, div_start, !div_busy, "divider restarted while busy")
  `SACEL_ASSERT_IMP(a_len_range, 1'b1, (seq_len_q != '0) && (32'(seq_len_q) <= SEQ_DEPTH), "sequence length out of range")
  `SACEL_ASSERT_IMP(a_pos_range, pc_q == ST_QMAP, pos_q < seq_len_q, "position past sequence end")

endmodule
